>>> rtl/jts_pkg.sv
// shared types, constants and literal tables for the json token scanner
package jts_pkg;

	localparam int MAX_DEPTH   = 16;
	localparam int TOKEN_BYTES = 64;
	localparam int LVL_W       = $clog2(MAX_DEPTH + 1);
	localparam int STK_AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int TOK_AW      = 6;
	localparam logic [TOK_AW-1:0] CNT_MAX = TOK_AW'(TOKEN_BYTES - 1);

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LC_E   = 8'h65;
	localparam logic [7:0] CH_UC_E   = 8'h45;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_R   = 8'h72;

	localparam logic [1:0] LIT_TRUE  = 2'd0;
	localparam logic [1:0] LIT_FALSE = 2'd1;
	localparam logic [1:0] LIT_NULL  = 2'd2;

	typedef enum logic [2:0] {
		M_SCAN = 3'd0,
		M_KEY  = 3'd1,
		M_STR  = 3'd2,
		M_NUM  = 3'd3,
		M_LIT  = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		EV_OBJS  = 4'd0,
		EV_OBJE  = 4'd1,
		EV_ARRS  = 4'd2,
		EV_ARRE  = 4'd3,
		EV_KEY   = 4'd4,
		EV_STR   = 4'd5,
		EV_NUM   = 4'd6,
		EV_TRUE  = 4'd7,
		EV_FALSE = 4'd8,
		EV_NULL  = 4'd9,
		EV_ERR   = 4'd10
	} ev_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEND,
		ST_TAIL,
		ST_APP2
	} fsm_t;

	typedef struct packed {
		mode_t             mode;
		logic              expv;
		logic              esc;
		logic              ovf;
		logic              err;
		logic [LVL_W-1:0]  level;
		logic [TOK_AW-1:0] count;
		logic [1:0]        litk;
		logic [2:0]        liti;
	} ctx_t;

	typedef struct packed {
		ctx_t              nxt;
		logic              ev_v;
		ev_t               ev_k;
		logic              tok_go;
		ev_t               tok_kind;
		logic [TOK_AW-1:0] tok_len;
		logic              wr_v;
		logic [TOK_AW-1:0] wr_a;
		logic [7:0]        wr_d;
		logic              push_v;
		logic              push_arr;
		logic              app2_v;
		logic [7:0]        app2_d;
	} step_t;

	function automatic logic [2:0] lit_len(input logic [1:0] k);
		return (k == LIT_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		unique case (k)
			LIT_TRUE: begin
				unique case (i)
					3'd0: r = 8'h74;
					3'd1: r = 8'h72;
					3'd2: r = 8'h75;
					3'd3: r = 8'h65;
					default: r = 8'h00;
				endcase
			end
			LIT_FALSE: begin
				unique case (i)
					3'd0: r = 8'h66;
					3'd1: r = 8'h61;
					3'd2: r = 8'h6C;
					3'd3: r = 8'h73;
					3'd4: r = 8'h65;
					default: r = 8'h00;
				endcase
			end
			default: begin
				unique case (i)
					3'd0: r = 8'h6E;
					3'd1: r = 8'h75;
					3'd2: r = 8'h6C;
					3'd3: r = 8'h6C;
					default: r = 8'h00;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

>>> rtl/jts_step.sv
// per-byte decode: next scanner context, events, token buffer writes and stack pushes
module jts_step (
	input  jts_pkg::ctx_t  cur,
	input  logic           top_arr,
	input  logic [7:0]     c,
	output jts_pkg::step_t st
);
	import jts_pkg::*;

	logic       inv;
	logic       app_v;
	logic [7:0] app_d;
	logic       do_scan;
	logic       send;
	ev_t        send_k;
	logic [1:0] k;
	logic [2:0] len;
	logic       is_digit;
	logic       is_numch;

	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_numch = is_digit || c == CH_DOT || c == CH_MINUS || c == CH_PLUS ||
		c == CH_LC_E || c == CH_UC_E;

	always_comb begin
		st      = '0;
		st.nxt  = cur;
		inv     = 1'b0;
		app_v   = 1'b0;
		app_d   = 8'h00;
		do_scan = 1'b0;
		send    = 1'b0;
		send_k  = EV_KEY;
		k       = (cur.litk == 2'd3) ? LIT_NULL : cur.litk;
		len     = lit_len(k);
		if (!cur.err) begin
			unique case (cur.mode)
				M_KEY, M_STR: begin
					if (cur.esc) begin
						st.nxt.esc = 1'b0;
						app_v      = 1'b1;
						if (c == CH_QUOTE || c == CH_BSL || c == CH_SLASH) app_d = c;
						else if (c == CH_LC_B) app_d = 8'h08;
						else if (c == CH_LC_F) app_d = 8'h0C;
						else if (c == CH_LC_N) app_d = 8'h0A;
						else if (c == CH_LC_R) app_d = 8'h0D;
						else if (c == CH_LC_T) app_d = 8'h09;
						else begin
							// unknown escape keeps the backslash and the byte
							app_d     = CH_BSL;
							st.app2_v = 1'b1;
							st.app2_d = c;
						end
					end else if (c == CH_BSL) begin
						st.nxt.esc = 1'b1;
					end else if (c == CH_QUOTE) begin
						send        = 1'b1;
						send_k      = (cur.mode == M_KEY) ? EV_KEY : EV_STR;
						if (cur.mode == M_STR) st.nxt.expv = 1'b0;
						st.nxt.mode = M_SCAN;
					end else begin
						app_v = 1'b1;
						app_d = c;
					end
				end
				M_NUM: begin
					if (is_numch) begin
						app_v = 1'b1;
						app_d = c;
					end else begin
						send        = 1'b1;
						send_k      = EV_NUM;
						st.nxt.mode = M_SCAN;
						st.nxt.expv = 1'b0;
						do_scan     = 1'b1;
					end
				end
				M_LIT: begin
					if (cur.liti < len && c == lit_char(k, cur.liti)) begin
						st.nxt.liti = cur.liti + 3'd1;
						if (cur.liti + 3'd1 == len) begin
							st.ev_v     = 1'b1;
							st.ev_k     = (k == LIT_TRUE) ? EV_TRUE :
								((k == LIT_FALSE) ? EV_FALSE : EV_NULL);
							st.nxt.mode = M_SCAN;
							st.nxt.expv = 1'b0;
						end
					end else begin
						st.nxt.err = 1'b1;
						st.ev_v    = 1'b1;
						st.ev_k    = EV_ERR;
					end
				end
				default: do_scan = 1'b1;
			endcase

			if (send && !cur.ovf) begin
				if (cur.count == '0) begin
					st.ev_v = 1'b1;
					st.ev_k = send_k;
				end else begin
					st.tok_go   = 1'b1;
					st.tok_kind = send_k;
					st.tok_len  = cur.count;
				end
			end

			if (do_scan) begin
				inv = st.nxt.expv || top_arr;
				if (c == CH_QUOTE) begin
					st.nxt.count = '0;
					st.nxt.ovf   = 1'b0;
					st.nxt.mode  = inv ? M_STR : M_KEY;
				end else if (c == CH_LBRACE || c == CH_LBRACK) begin
					if (cur.level < LVL_W'(MAX_DEPTH)) begin
						st.push_v    = 1'b1;
						st.push_arr  = (c == CH_LBRACK);
						st.nxt.level = cur.level + 1'b1;
						st.ev_v      = 1'b1;
						st.ev_k      = (c == CH_LBRACK) ? EV_ARRS : EV_OBJS;
						st.nxt.expv  = 1'b0;
					end else begin
						st.nxt.err = 1'b1;
						st.ev_v    = 1'b1;
						st.ev_k    = EV_ERR;
					end
				end else if (c == CH_RBRACE || c == CH_RBRACK) begin
					st.ev_v = 1'b1;
					st.ev_k = (c == CH_RBRACE) ? EV_OBJE : EV_ARRE;
					if (cur.level != '0) st.nxt.level = cur.level - 1'b1;
					st.nxt.expv = 1'b0;
				end else if (c == CH_COLON) begin
					st.nxt.expv = 1'b1;
				end else if (c == CH_COMMA) begin
					st.nxt.expv = 1'b0;
				end else if (c == CH_LC_T || c == CH_LC_F || c == CH_LC_N) begin
					if (inv) begin
						st.nxt.litk = (c == CH_LC_T) ? LIT_TRUE :
							((c == CH_LC_F) ? LIT_FALSE : LIT_NULL);
						st.nxt.liti = 3'd1;
						st.nxt.mode = M_LIT;
					end
				end else if (inv && (c == CH_MINUS || is_digit)) begin
					st.nxt.count = '0;
					st.nxt.ovf   = 1'b0;
					app_v        = 1'b1;
					app_d        = c;
					st.nxt.mode  = M_NUM;
				end
			end

			if (app_v) begin
				if (st.nxt.count < CNT_MAX) begin
					st.wr_v      = 1'b1;
					st.wr_a      = st.nxt.count;
					st.wr_d      = app_d;
					st.nxt.count = st.nxt.count + 1'b1;
				end else begin
					st.nxt.ovf = 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/json_token_scanner.sv
// top level of the json token scanner: control sequencer, token buffer and nesting stack
// output: a byte with a plain event shows it in the cycle after the input beat
// throughput: one byte per cycle with at most one event, while the output register is free; a
//   token is sent character by character, set by the one-read-per-cycle port of the token
//   buffer, then any trailing event; an unknown escape makes its second buffer write in ST_APP2
// reset: arst_n clears the scan context and handshake state; buffer and stack hold no reset
module json_token_scanner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       restart,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] event_kind,
	output logic [7:0] token_char,
	output logic       char_valid,
	output logic [5:0] token_length,
	output logic       last
);
	import jts_pkg::*;

	// scan context and sequencer
	fsm_t  state_q, state_d;
	ctx_t  ctx_q, ctx_d, cur;
	step_t st;

	// nesting stack, one bit per level (1 = array)
	logic [MAX_DEPTH-1:0] stk_q;
	logic [LVL_W-1:0]     lvl_m1;
	logic                 top_arr;

	// token buffer: one write and one registered read per cycle
	logic [7:0]        mem [TOKEN_BYTES];
	logic [7:0]        rd_data_q;
	logic [TOK_AW-1:0] rd_addr;
	logic              we;
	logic [TOK_AW-1:0] wa;
	logic [7:0]        wd;

	// token read-out bookkeeping
	logic [TOK_AW-1:0] rd_idx_q, rd_idx_d;
	logic [TOK_AW-1:0] send_len_q;
	ev_t               send_kind_q;
	logic              tail_v_q;
	ev_t               tail_k_q;
	logic [7:0]        app2_q;

	// output register, parts the two sides of the block
	logic              out_valid_q;
	ev_t               out_kind_q;
	logic [7:0]        out_char_q;
	logic              out_cv_q;
	logic [TOK_AW-1:0] out_len_q;
	logic              out_last_q;

	logic              slot_free;
	logic              acc;
	logic              last_chr;
	logic              ld;
	ev_t               ld_kind;
	logic [7:0]        ld_char;
	logic              ld_cv;
	logic [TOK_AW-1:0] ld_len;
	logic              ld_last;

	// restart clears the context before the byte is looked at
	always_comb begin
		cur = ctx_q;
		if (restart) begin
			cur      = '0;
			cur.mode = M_SCAN;
		end
	end

	assign lvl_m1  = cur.level - 1'b1;
	assign top_arr = (cur.level != '0) && stk_q[lvl_m1[STK_AW-1:0]];

	jts_step u_step (
		.cur     (cur),
		.top_arr (top_arr),
		.c       (data_byte),
		.st      (st)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign acc       = in_valid && in_ready;
	assign last_chr  = (rd_idx_q == send_len_q - 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (st.tok_go) state_d = ST_SEND;
					else if (st.app2_v) state_d = ST_APP2;
				end
			end
			ST_SEND: begin
				if (slot_free && last_chr) state_d = tail_v_q ? ST_TAIL : ST_IDLE;
			end
			ST_TAIL: begin
				if (slot_free) state_d = ST_IDLE;
			end
			ST_APP2: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control per state
	always_comb begin
		ld       = 1'b0;
		ld_kind  = send_kind_q;
		ld_char  = 8'h00;
		ld_cv    = 1'b0;
		ld_len   = '0;
		ld_last  = 1'b1;
		we       = 1'b0;
		wa       = '0;
		wd       = 8'h00;
		ctx_d    = ctx_q;
		rd_idx_d = rd_idx_q;
		rd_addr  = rd_idx_q;
		unique case (state_q)
			ST_IDLE: begin
				// prime the buffer read at the first character
				rd_idx_d = '0;
				rd_addr  = '0;
				if (acc) begin
					ctx_d = st.nxt;
					we    = st.wr_v;
					wa    = st.wr_a;
					wd    = st.wr_d;
					if (st.ev_v && !st.tok_go) begin
						ld      = 1'b1;
						ld_kind = st.ev_k;
					end
				end
			end
			ST_SEND: begin
				if (slot_free) begin
					ld       = 1'b1;
					ld_kind  = send_kind_q;
					ld_char  = rd_data_q;
					ld_cv    = 1'b1;
					ld_len   = send_len_q;
					ld_last  = last_chr && !tail_v_q;
					rd_idx_d = rd_idx_q + 1'b1;
					rd_addr  = rd_idx_d;
				end
			end
			ST_TAIL: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_kind = tail_k_q;
				end
			end
			ST_APP2: begin
				// second byte of an unknown escape
				if (ctx_q.count < CNT_MAX) begin
					we          = 1'b1;
					wa          = ctx_q.count;
					wd          = app2_q;
					ctx_d.count = ctx_q.count + 1'b1;
				end else begin
					ctx_d.ovf = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctx_q       <= '0;
			out_valid_q <= 1'b0;
			rd_idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			ctx_q    <= ctx_d;
			rd_idx_q <= rd_idx_d;
			if (ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld) begin
			out_kind_q <= ld_kind;
			out_char_q <= ld_char;
			out_cv_q   <= ld_cv;
			out_len_q  <= ld_len;
			out_last_q <= ld_last;
		end
		if (acc) begin
			send_len_q  <= st.tok_len;
			send_kind_q <= st.tok_kind;
			tail_v_q    <= st.ev_v;
			tail_k_q    <= st.ev_k;
			app2_q      <= st.app2_d;
		end
		if (acc && st.push_v) stk_q[cur.level[STK_AW-1:0]] <= st.push_arr;
	end

	// token buffer
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_data_q <= mem[rd_addr];
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_kind_q;
	assign token_char   = out_char_q;
	assign char_valid   = out_cv_q;
	assign token_length = 6'(out_len_q);
	assign last         = out_last_q;

`ifndef SYNTHESIS
	a_cv_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> token_length != '0)
		else $error("character beat with zero token length");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.count <= CNT_MAX)
		else $error("token count beyond buffer");

	a_lvl_max: assert property (@(posedge clk) disable iff (!arst_n)
		ctx_q.level <= LVL_W'(MAX_DEPTH))
		else $error("nesting level beyond stack depth");

	a_rd_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND |-> rd_idx_q < send_len_q)
		else $error("buffer read past token end");
`endif

endmodule
